FILE: hdl/rgbw_led_effect_pixel_generator_top_assert.svh
// ----------------------------------------------------------------------------
// RGBW pixel effect generator - assertion macros
// Concurrent assertion helpers shared by the generator RTL.
// ----------------------------------------------------------------------------
`ifndef RGBW_LED_EFFECT_PIXEL_GENERATOR_TOP_ASSERT_SVH
`define RGBW_LED_EFFECT_PIXEL_GENERATOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define RGBWFX_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rgbwfx: same-cycle implication violated");

// next-cycle implication
`define RGBWFX_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rgbwfx: next-cycle implication violated");

`else

`define RGBWFX_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RGBWFX_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: hdl/rgbwfx_pkg.sv
// ----------------------------------------------------------------------------
// RGBW pixel effect generator - package
// Shared payload types, register indexes and effect codes.
// ----------------------------------------------------------------------------
package rgbwfx_pkg;

  localparam int unsigned MaxPixels = 256;   // rainbow spread divisor ceiling
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CntW      = 9;
  localparam int unsigned DivStages = 4;     // stages of the spread divider

  typedef enum logic [CfgIdxW-1:0] {
    RegPowerOn    = 2'd0,
    RegEffectMode = 2'd1,
    RegBaseColor  = 2'd2,
    RegPixelCount = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ModeStatic  = 2'd0,
    ModeBreathe = 2'd1,
    ModeRainbow = 2'd2
  } effect_mode_e;

  typedef struct packed {
    logic [31:0] time_ms;
    logic [7:0]  pixel_index;
  } px_in_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic [7:0] white_level;
  } px_out_t;

endpackage

FILE: hdl/rgbwfx_spread_div.sv
// ----------------------------------------------------------------------------
// RGBW pixel effect generator - rainbow spread divider
// Pipelined restoring division of (index * 256) by the pixel count; gives
// the low eight quotient bits after DivStages register stages.
// ----------------------------------------------------------------------------
module rgbwfx_spread_div (
  input  logic                                 clk_i,
  input  logic [rgbwfx_pkg::DivStages-1:0]     en_i,
  input  logic [7:0]                           idx_i,
  input  logic [rgbwfx_pkg::CntW-1:0]          cnt_i,
  output logic [7:0]                           quot_o
);

  localparam int unsigned DvdW          = 16;   // {index, 8'h00}
  localparam int unsigned StepsPerStage = DvdW / rgbwfx_pkg::DivStages;

  logic [rgbwfx_pkg::CntW-1:0] rem_q  [rgbwfx_pkg::DivStages];
  logic [7:0]                  quot_q [rgbwfx_pkg::DivStages];
  logic [7:0]                  idx_q  [rgbwfx_pkg::DivStages-1];

  for (genvar s = 0; s < rgbwfx_pkg::DivStages; s++) begin : g_stage
    logic [rgbwfx_pkg::CntW-1:0] rem_in;
    logic [rgbwfx_pkg::CntW-1:0] rem_d;
    logic [7:0]                  quot_in;
    logic [7:0]                  quot_d;
    logic [7:0]                  idx_in;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign quot_in = '0;
      assign idx_in  = idx_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign quot_in = quot_q[s-1];
      assign idx_in  = idx_q[s-1];
    end

    always_comb begin
      logic [DvdW-1:0]           dvd;
      logic [rgbwfx_pkg::CntW:0] trial;
      logic                      qbit;
      int unsigned               j;
      dvd    = {idx_in, 8'h00};
      rem_d  = rem_in;
      quot_d = quot_in;
      for (int unsigned i = 0; i < StepsPerStage; i++) begin
        j     = s * StepsPerStage + i;
        trial = {rem_d, dvd[4'(DvdW - 1 - j)]};
        if (trial >= {1'b0, cnt_i}) begin
          rem_d = rgbwfx_pkg::CntW'(trial - {1'b0, cnt_i});
          qbit  = 1'b1;
        end else begin
          rem_d = trial[rgbwfx_pkg::CntW-1:0];
          qbit  = 1'b0;
        end
        quot_d = {quot_d[6:0], qbit};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s]  <= rem_d;
        quot_q[s] <= quot_d;
      end
    end

    if (s < rgbwfx_pkg::DivStages - 1) begin : g_idx
      always_ff @(posedge clk_i) begin
        if (en_i[s]) begin
          idx_q[s] <= idx_in;
        end
      end
    end
  end

  assign quot_o = quot_q[rgbwfx_pkg::DivStages-1];

endmodule

FILE: hdl/rgbw_led_effect_pixel_generator_top.sv
// ----------------------------------------------------------------------------
// RGBW pixel effect generator - top level
// Per-pixel RGBW colour for static, breathe and rainbow effects.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one request
//   transaction: a millisecond time stamp and a pixel index. Output channel
//   (out_valid_o / out_stall_i / out_data_o) returns exactly one transaction
//   per request: the echoed index and the red, green, blue and white bytes.
//   A transaction moves on a rising edge with valid high and stall low.
//   out_valid_o rises once the request reaches the last of the eight stages;
//   the pipeline takes a new request every cycle while in_stall_o is low, so
//   throughput is one pixel per clock without back-pressure. Stage depth
//   is set by the 32x21 reciprocal multiply of the breathe phase and by four
//   restoring division steps per stage in the rainbow spread divider.
//   When the receiver stalls, each stage holds its transaction and the
//   bubbles ahead of it fill up; in_stall_o rises only once all eight stages
//   hold valid data and the output is stalled.
//   Configuration (cfg_we_i / cfg_idx_i / cfg_wdata_i) is written by the user
//   only while the block is idle (not enforced). Reset empties the pipeline
//   and returns power off, static mode, black base colour, pixel count 256.
// ----------------------------------------------------------------------------
`include "rgbw_led_effect_pixel_generator_top_assert.svh"

module rgbw_led_effect_pixel_generator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rgbwfx_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [rgbwfx_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  rgbwfx_pkg::px_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output rgbwfx_pkg::px_out_t                 out_data_o
);

  localparam int unsigned NumStages = 8;

  // breathe: phase = floor((t mod 3060) / 6)
  localparam logic [20:0] BrRecip  = 21'd1403584;  // floor(2^32 / 3060)
  localparam logic [11:0] BrPeriod = 12'd3060;
  localparam logic [15:0] Div6Mul  = 16'd43691;    // ceil(2^18 / 6)
  // rainbow: floor(t / 20) mod 256 = floor(((t mod 5120) >> 2) / 5)
  localparam logic [10:0] Div5Mul  = 11'd1639;     // ceil(2^13 / 5)

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                            power_on_q;
  logic [1:0]                      effect_mode_q;
  logic [31:0]                     base_color_q;
  logic [rgbwfx_pkg::CntW-1:0]     pixel_count_q;
  logic [rgbwfx_pkg::CntW-1:0]     cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_on_q    <= 1'b0;
      effect_mode_q <= rgbwfx_pkg::ModeStatic;
      base_color_q  <= '0;
      pixel_count_q <= 9'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rgbwfx_pkg::RegPowerOn:    power_on_q    <= cfg_wdata_i[0];
        rgbwfx_pkg::RegEffectMode: effect_mode_q <= cfg_wdata_i[1:0];
        rgbwfx_pkg::RegBaseColor:  base_color_q  <= cfg_wdata_i[31:0];
        rgbwfx_pkg::RegPixelCount: pixel_count_q <= cfg_wdata_i[rgbwfx_pkg::CntW-1:0];
      endcase
    end
  end

  // zero count acts as one, large counts saturate
  always_comb begin
    if (pixel_count_q == '0) begin
      cnt = rgbwfx_pkg::CntW'(1);
    end else if (32'(pixel_count_q) > rgbwfx_pkg::MaxPixels) begin
      cnt = rgbwfx_pkg::CntW'(rgbwfx_pkg::MaxPixels);
    end else begin
      cnt = pixel_count_q;
    end
  end

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  // x mod 5 for a 22-bit value; 16 = 1 (mod 5) so nibbles fold
  function automatic logic [2:0] mod5_22(input logic [21:0] v);
    logic [6:0] s;
    logic [4:0] f;
    logic [4:0] r;
    s = 7'(v[3:0]) + 7'(v[7:4]) + 7'(v[11:8]) + 7'(v[15:12])
      + 7'(v[19:16]) + 7'(v[21:20]);
    f = 5'(s[3:0]) + 5'(s[6:4]);   // at most 18
    priority if (f >= 5'd15) r = f - 5'd15;
    else if (f >= 5'd10)     r = f - 5'd10;
    else if (f >= 5'd5)      r = f - 5'd5;
    else                     r = f;
    return r[2:0];
  endfunction

  // floor(x / 255), exact for x below 2^16 - 256
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'd1 + 17'(x[15:8]);
    return s[15:8];
  endfunction

  // --------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when empty or when its successor
  // loads, so bubbles are squeezed out under stall.
  // --------------------------------------------------------------------------
  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;

  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // pixel index rides alongside
  logic [7:0] idx_q [NumStages-1];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      idx_q[0] <= in_data_i.pixel_index;
    end
    for (int k = 1; k < NumStages - 1; k++) begin
      if (en[k]) begin
        idx_q[k] <= idx_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: reciprocal estimate of t / 3060, rainbow time residue
  // --------------------------------------------------------------------------
  logic [31:0] t0_q;
  logic [20:0] q0_q;
  logic [10:0] tv0_q;
  logic [52:0] prod0_d;

  assign prod0_d = 53'(in_data_i.time_ms) * 53'(BrRecip);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      t0_q  <= in_data_i.time_ms;
      q0_q  <= prod0_d[52:32];
      tv0_q <= {mod5_22(in_data_i.time_ms[31:10]), in_data_i.time_ms[9:2]};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: raw remainder (below twice the period), rainbow time position
  // --------------------------------------------------------------------------
  logic [12:0] rr1_q;
  logic [7:0]  ps1_q;
  logic [32:0] rr1_d;
  logic [21:0] ps1_d;

  assign rr1_d = {1'b0, t0_q} - (33'(q0_q) * 33'(BrPeriod));
  assign ps1_d = 22'(tv0_q) * 22'(Div5Mul);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      rr1_q <= rr1_d[12:0];
      ps1_q <= ps1_d[20:13];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: remainder correction
  // --------------------------------------------------------------------------
  logic [11:0] r2_q;
  logic [7:0]  ps2_q;
  logic [12:0] r2_d;

  assign r2_d = (rr1_q >= 13'(BrPeriod)) ? (rr1_q - 13'(BrPeriod)) : rr1_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      r2_q  <= r2_d[11:0];
      ps2_q <= ps1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: breathe phase = r / 6
  // --------------------------------------------------------------------------
  logic [8:0]  ph3_q;
  logic [7:0]  ps3_q;
  logic [27:0] ph3_d;

  assign ph3_d = 28'(r2_q) * 28'(Div6Mul);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      ph3_q <= ph3_d[26:18];
      ps3_q <= ps2_q;
    end
  end

  // spread divider runs alongside stages 0 to 3
  logic [7:0] spread;

  rgbwfx_spread_div u_spread_div (
    .clk_i  (clk_i),
    .en_i   (en[rgbwfx_pkg::DivStages-1:0]),
    .idx_i  (in_data_i.pixel_index),
    .cnt_i  (cnt),
    .quot_o (spread)
  );

  // --------------------------------------------------------------------------
  // Stage 4: triangle wave product, colour wheel
  // --------------------------------------------------------------------------
  logic [15:0] tx4_q;
  logic [23:0] rgb4_q;
  logic [7:0]  tri4;
  logic [8:0]  mir4;
  logic [7:0]  pos4;
  logic [7:0]  p4;
  logic [7:0]  pw4;
  logic [23:0] rgb4_d;

  assign mir4 = 9'd510 - ph3_q;
  assign tri4 = (ph3_q <= 9'd255) ? ph3_q[7:0] : mir4[7:0];
  assign pos4 = ps3_q + spread;
  assign p4   = 8'd255 - pos4;

  // reversed wheel: three 85-step ramps
  always_comb begin
    if (p4 < 8'd85) begin
      pw4    = 8'(p4 * 8'd3);
      rgb4_d = {8'd255 - pw4, 8'd0, pw4};
    end else if (p4 < 8'd170) begin
      pw4    = 8'((p4 - 8'd85) * 8'd3);
      rgb4_d = {8'd0, pw4, 8'd255 - pw4};
    end else begin
      pw4    = 8'((p4 - 8'd170) * 8'd3);
      rgb4_d = {pw4, 8'd255 - pw4, 8'd0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      tx4_q  <= 16'(tri4) * 16'd191;
      rgb4_q <= rgb4_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: breathe level, 64 to 255
  // --------------------------------------------------------------------------
  logic [7:0]  lvl5_q;
  logic [23:0] rgb5_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      lvl5_q <= 8'd64 + div255(tx4_q);
      rgb5_q <= rgb4_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: channel times level
  // --------------------------------------------------------------------------
  logic [15:0] prod6_q [4];
  logic [23:0] rgb6_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      for (int k = 0; k < 4; k++) begin
        prod6_q[k] <= 16'(base_color_q[31 - 8*k -: 8]) * 16'(lvl5_q);
      end
      rgb6_q <= rgb5_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: effect select, output register
  // --------------------------------------------------------------------------
  rgbwfx_pkg::px_out_t out_d;
  rgbwfx_pkg::px_out_t out_q;

  always_comb begin
    out_d.pixel_out = idx_q[NumStages-2];
    if (!power_on_q) begin
      out_d.red_level   = '0;
      out_d.green_level = '0;
      out_d.blue_level  = '0;
      out_d.white_level = '0;
    end else begin
      unique case (effect_mode_q)
        rgbwfx_pkg::ModeBreathe: begin
          out_d.red_level   = div255(prod6_q[0]);
          out_d.green_level = div255(prod6_q[1]);
          out_d.blue_level  = div255(prod6_q[2]);
          out_d.white_level = div255(prod6_q[3]);
        end
        rgbwfx_pkg::ModeRainbow: begin
          out_d.red_level   = rgb6_q[23:16];
          out_d.green_level = rgb6_q[15:8];
          out_d.blue_level  = rgb6_q[7:0];
          out_d.white_level = '0;
        end
        default: begin
          // static, and the spare code behaves as static
          out_d.red_level   = base_color_q[31:24];
          out_d.green_level = base_color_q[23:16];
          out_d.blue_level  = base_color_q[15:8];
          out_d.white_level = base_color_q[7:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NumStages-1]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // back-pressure only reaches the input when every stage is occupied
  `RGBWFX_ASSERT_IMP(a_stall_only_when_full, clk_i, rst_ni, in_stall_o, out_stall_i && (&v_q))
  // an empty output stage always lets a request in
  `RGBWFX_ASSERT_IMP(a_accept_when_drained, clk_i, rst_ni, !out_valid_o, !in_stall_o)
  // an accepted transaction occupies the first stage next cycle
  `RGBWFX_ASSERT_NXT(a_accept_enters, clk_i, rst_ni, in_valid_i && !in_stall_o, v_q[0])

endmodule

FILE: bench/tb_rgbw_led_effect_pixel_generator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGBW pixel effect generator - testbench
// Drives pixel requests through the valid/stall channels under several
// register settings, predicts each pixel's RGBW bytes from a local copy of
// the registers, and checks every returned transaction in order.
// ----------------------------------------------------------------------------
module tb_rgbw_led_effect_pixel_generator_top;

  localparam int unsigned PipeLatency   = 8;       // accepting edge to earliest result edge
  localparam int unsigned CycleLimit    = 400000;  // far above the slowest good run
  localparam logic [1:0]  ModeStaticAlt = 2'd3;    // spare mode code, behaves as static

  // --------------------------------------------------------------------------
  // DUT connections, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            cfg_we_i    = 1'b0;
  logic [rgbwfx_pkg::CfgIdxW-1:0]  cfg_idx_i   = rgbwfx_pkg::RegPowerOn;
  logic [rgbwfx_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  rgbwfx_pkg::px_in_t              in_data_i   = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  rgbwfx_pkg::px_out_t             out_data_o;

  // Shadow of the configuration registers, reset values as in the block
  logic        lit_q       = 1'b0;
  logic [1:0]  mode_q      = rgbwfx_pkg::ModeStatic;
  logic [31:0] colour_q    = '0;
  logic [8:0]  strip_len_q = 9'd256;

  // Pixels still owed by the block, oldest first
  rgbwfx_pkg::px_out_t pending_pixels[$];

  int unsigned send_idle_pct  = 28;
  int unsigned recv_stall_pct = 87;
  int unsigned pixels_sent    = 0;
  int unsigned pixels_checked = 0;
  int unsigned reg_writes     = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  rgbw_led_effect_pixel_generator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Colour prediction for one request under the current shadow registers
  // --------------------------------------------------------------------------
  function automatic rgbwfx_pkg::px_out_t pixel_colour_for(rgbwfx_pkg::px_in_t req);
    rgbwfx_pkg::px_out_t res;
    int unsigned t, phase, tri_lvl, level, cnt, pos, p, k;
    int unsigned chan [4];
    t = req.time_ms;
    for (k = 0; k < 4; k++) begin
      chan[k] = colour_q[31 - 8 * k -: 8];
    end
    case (mode_q)
      rgbwfx_pkg::ModeBreathe: begin
        // triangle over a 510-step cycle, six milliseconds per step
        phase   = (t / 6) % 510;
        tri_lvl = (phase <= 255) ? phase : 510 - phase;
        level   = 64 + (tri_lvl * 191) / 255;
        for (k = 0; k < 4; k++) begin
          chan[k] = (chan[k] * level) / 255;
        end
      end
      rgbwfx_pkg::ModeRainbow: begin
        // zero counts as one, anything past the strip maximum saturates
        cnt = strip_len_q;
        if (cnt == 0) cnt = 1;
        if (cnt > rgbwfx_pkg::MaxPixels) cnt = rgbwfx_pkg::MaxPixels;
        pos = ((t / 20) + (int'(req.pixel_index) * 256) / cnt) & 8'hFF;
        p   = 255 - pos;   // wheel runs backwards
        chan[3] = 0;
        if (p < 85) begin
          chan[0] = 255 - p * 3;
          chan[1] = 0;
          chan[2] = p * 3;
        end else if (p < 170) begin
          p = p - 85;
          chan[0] = 0;
          chan[1] = p * 3;
          chan[2] = 255 - p * 3;
        end else begin
          p = p - 170;
          chan[0] = p * 3;
          chan[1] = 255 - p * 3;
          chan[2] = 0;
        end
      end
      default: ;   // static and the spare code keep the base colour
    endcase
    if (!lit_q) begin
      for (k = 0; k < 4; k++) begin
        chan[k] = 0;
      end
    end
    res.pixel_out   = req.pixel_index;
    res.red_level   = chan[0][7:0];
    res.green_level = chan[1][7:0];
    res.blue_level  = chan[2][7:0];
    res.white_level = chan[3][7:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking: every accepted output transaction against the oldest
  // outstanding prediction
  // --------------------------------------------------------------------------
  task automatic compare_level(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    rgbwfx_pkg::px_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %h", $time, out_data_o);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        compare_level("pixel_out",   want.pixel_out,   out_data_o.pixel_out);
        compare_level("red_level",   want.red_level,   out_data_o.red_level);
        compare_level("green_level", want.green_level, out_data_o.green_level);
        compare_level("blue_level",  want.blue_level,  out_data_o.blue_level);
        compare_level("white_level", want.white_level, out_data_o.white_level);
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------
  // One request transaction; valid stays high afterwards so back-to-back
  // requests need no extra edge. The prediction is queued at acceptance.
  task automatic send_pixel(input logic [31:0] t, input logic [7:0] idx);
    rgbwfx_pkg::px_in_t req;
    req.time_ms     = t;
    req.pixel_index = idx;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_pixels.push_back(pixel_colour_for(req));
    pixels_sent++;
  endtask

  // Drop valid and hold off until every owed pixel has come back
  task automatic wait_for_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  // Register write; the shadow keeps only the bits the register holds
  task automatic write_reg(input rgbwfx_pkg::cfg_reg_e idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      rgbwfx_pkg::RegPowerOn:    lit_q       = value[0];
      rgbwfx_pkg::RegEffectMode: mode_q      = value[1:0];
      rgbwfx_pkg::RegBaseColor:  colour_q    = value;
      rgbwfx_pkg::RegPixelCount: strip_len_q = value[8:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  function automatic logic [31:0] random_time();
    case ($urandom_range(3))
      0:       return $urandom_range(20000);
      1:       return 32'hFFFF_FFFF - $urandom_range(20000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] random_index();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return $urandom_range(255);
    endcase
  endfunction

  // New random settings, junk in the unused upper data bits
  task automatic load_random_settings();
    logic [31:0] junk;
    logic [31:0] colour;
    logic [8:0]  cnt;
    junk = $urandom;
    write_reg(rgbwfx_pkg::RegPowerOn, {junk[31:1], ($urandom_range(9) != 0)});
    junk = $urandom;
    write_reg(rgbwfx_pkg::RegEffectMode, {junk[31:2], 2'($urandom_range(3))});
    case ($urandom_range(5))
      0:       colour = '0;
      1:       colour = '1;
      default: colour = $urandom;
    endcase
    write_reg(rgbwfx_pkg::RegBaseColor, colour);
    case ($urandom_range(5))
      0:       cnt = 9'd0;
      1:       cnt = 9'd1;
      2:       cnt = 9'd256;
      3:       cnt = 9'($urandom_range(257, 511));
      default: cnt = 9'($urandom_range(2, 255));
    endcase
    junk = $urandom;
    write_reg(rgbwfx_pkg::RegPixelCount, {junk[31:9], cnt});
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Straight out of reset: power off, so only the index echo survives
  task automatic test_reset_state();
    send_pixel(32'h0000_0000, 8'd0);
    send_pixel(32'hFFFF_FFFF, 8'd255);
    wait_for_drain();
  endtask

  // Base colour repeated; spare mode code must behave the same
  task automatic test_static_colour();
    write_reg(rgbwfx_pkg::RegPowerOn, 32'h0000_0001);
    write_reg(rgbwfx_pkg::RegBaseColor, 32'hA5C3_5A3C);
    send_pixel(32'h0000_0000, 8'd0);
    send_pixel(32'hFFFF_FFFF, 8'd255);
    wait_for_drain();
    write_reg(rgbwfx_pkg::RegEffectMode, {30'h3FFF_FFFF, ModeStaticAlt});
    send_pixel(32'h1234_5678, 8'd17);
    wait_for_drain();
    write_reg(rgbwfx_pkg::RegBaseColor, 32'hFFFF_FFFF);
    send_pixel(32'h8000_0000, 8'd128);
    wait_for_drain();
  endtask

  // Triangle corners: bottom, top, just past the top, last step, wrap
  task automatic test_breathe_wave();
    write_reg(rgbwfx_pkg::RegEffectMode, {30'd0, rgbwfx_pkg::ModeBreathe});
    write_reg(rgbwfx_pkg::RegBaseColor, 32'hFF80_017F);
    send_pixel(32'd0,    8'd3);
    send_pixel(32'd1530, 8'd4);
    send_pixel(32'd1536, 8'd5);
    send_pixel(32'd3054, 8'd6);
    send_pixel(32'd3060, 8'd7);
    send_pixel(32'hFFFF_FFFF, 8'd255);
    wait_for_drain();
  endtask

  // Wheel segment edges with the reset strip length, then the count corners
  task automatic test_rainbow_wheel();
    write_reg(rgbwfx_pkg::RegEffectMode, {30'd0, rgbwfx_pkg::ModeRainbow});
    send_pixel(32'd0, 8'd0);
    send_pixel(32'd0, 8'd85);
    send_pixel(32'd0, 8'd170);
    send_pixel(32'd0, 8'd255);
    send_pixel(32'hFFFF_FFFF, 8'd255);
    wait_for_drain();
    write_reg(rgbwfx_pkg::RegPixelCount, 32'd0);       // zero count acts as one
    send_pixel(32'd40, 8'd1);
    wait_for_drain();
    write_reg(rgbwfx_pkg::RegPixelCount, 32'd511);     // saturates at the strip maximum
    send_pixel(32'd999, 8'd200);
    wait_for_drain();
    write_reg(rgbwfx_pkg::RegPixelCount, 32'd3);       // index well past the strip end
    send_pixel(32'd20, 8'd255);
    wait_for_drain();
  endtask

  // Power off with rainbow still selected; upper data bits are ignored
  task automatic test_power_off();
    write_reg(rgbwfx_pkg::RegPowerOn, 32'hFFFF_FFFE);
    send_pixel(32'hDEAD_BEEF, 8'd77);
    wait_for_drain();
  endtask

  // Random traffic in batches, each batch under fresh settings written while
  // the pipeline is empty; now and then the sender holds off until drained
  task automatic run_random_phase(input int unsigned n_items, input int unsigned send_pct,
                                  input int unsigned recv_pct);
    int unsigned done;
    int unsigned batch_len;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    done = 0;
    while (done < n_items) begin
      wait_for_drain();
      load_random_settings();
      batch_len = $urandom_range(20, 90);
      repeat (batch_len) begin
        send_pixel(random_time(), random_index());
        if ($urandom_range(99) == 0) wait_for_drain();
      end
      done += batch_len;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_static_colour();
    test_breathe_wave();
    test_rainbow_wheel();
    test_power_off();

    // sender lazy / receiver busy, then the reverse, then full rate
    run_random_phase(560, 28, 87);
    run_random_phase(560, 87, 28);
    run_random_phase(560, 0, 0);

    wait_for_drain();
    repeat (PipeLatency * 2) @(posedge clk_i);

    $display("Covered %0d pixel requests, %0d results checked, %0d register writes.",
             pixels_sent, pixels_checked, reg_writes);
    $display("Modes static, breathe, rainbow and spare code, power on and off, %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: rgbw_led_effect_pixel_generator_top.f
+incdir+hdl
hdl/rgbwfx_pkg.sv
hdl/rgbwfx_spread_div.sv
hdl/rgbw_led_effect_pixel_generator_top.sv
bench/tb_rgbw_led_effect_pixel_generator_top.sv
